// ===== src/dpd_pkg.sv =====
// Package for the debug packet deframer: receive modes, result kinds,
// framing characters, the result record and the hex digit decoder.
// No dependencies.
package dpd_pkg;

	localparam int MaxPayloadDef = 512;
	localparam int ByteW         = 8;
	localparam int CountW        = 10;

	localparam logic [ByteW-1:0] ChStart  = 8'h24; // '$'
	localparam logic [ByteW-1:0] ChEnd    = 8'h23; // '#'
	localparam logic [ByteW-1:0] ChEscape = 8'h7D; // '}'
	localparam logic [ByteW-1:0] EscXor   = 8'h20;

	typedef enum logic [2:0] {
		MODE_HUNT = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_CK1  = 3'd3,
		MODE_CK2  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_GOOD    = 3'd1,
		KIND_BAD     = 3'd2,
		KIND_OVER    = 3'd3,
		KIND_STRAY   = 3'd4,
		KIND_RESTART = 3'd5
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ByteW-1:0]  data;
		logic [CountW-1:0] count;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one ASCII hex digit, either case; a non-hex byte reads as zero.
	function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.val = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== src/dpd_engine.sv =====
// Deframing state and per-byte decision logic for the debug packet deframer.
// Depends on dpd_pkg.
module dpd_engine #(
	parameter int MAX_PAYLOAD = dpd_pkg::MaxPayloadDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [dpd_pkg::ByteW-1:0]  byte_s1,
	output dpd_pkg::result_t           res
);

	localparam int LenW = $clog2(MAX_PAYLOAD);

	dpd_pkg::mode_t              mode_q, mode_d;
	logic [dpd_pkg::ByteW-1:0]   sum_q, sum_d;
	logic [LenW-1:0]             len_q, len_d;
	logic [3:0]                  hi_q, hi_d;
	logic                        bad_q, bad_d;

	logic                        do_pay;
	logic [dpd_pkg::ByteW-1:0]   pay_b;
	logic [LenW:0]               len_inc;
	logic [LenW+dpd_pkg::CountW-1:0] len_ext;
	dpd_pkg::hex_t               hex;

	assign len_inc = {1'b0, len_q} + {{LenW{1'b0}}, 1'b1};
	assign len_ext = {{dpd_pkg::CountW{1'b0}}, len_q};
	assign hex     = dpd_pkg::hex_decode(byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dpd_pkg::MODE_HUNT;
			sum_q  <= '0;
			len_q  <= '0;
			hi_q   <= '0;
			bad_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			sum_q  <= sum_d;
			len_q  <= len_d;
			hi_q   <= hi_d;
			bad_q  <= bad_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		sum_d     = sum_q;
		len_d     = len_q;
		hi_d      = hi_q;
		bad_d     = bad_q;
		do_pay    = 1'b0;
		pay_b     = byte_s1;
		res.valid = 1'b0;
		res.kind  = dpd_pkg::KIND_DATA;
		res.data  = '0;
		res.count = '0;

		case (mode_q)
			dpd_pkg::MODE_BODY: begin
				if (byte_s1 == dpd_pkg::ChEnd) begin
					mode_d = dpd_pkg::MODE_CK1;
				end else if (byte_s1 == dpd_pkg::ChStart) begin
					sum_d     = '0;
					len_d     = '0;
					res.valid = 1'b1;
					res.kind  = dpd_pkg::KIND_RESTART;
				end else begin
					sum_d = sum_q + byte_s1;
					if (byte_s1 == dpd_pkg::ChEscape) begin
						mode_d = dpd_pkg::MODE_ESC;
					end else begin
						do_pay = 1'b1;
					end
				end
			end
			dpd_pkg::MODE_ESC: begin
				sum_d  = sum_q + byte_s1;
				do_pay = 1'b1;
				pay_b  = byte_s1 ^ dpd_pkg::EscXor;
			end
			dpd_pkg::MODE_CK1: begin
				hi_d   = hex.val;
				bad_d  = !hex.ok;
				mode_d = dpd_pkg::MODE_CK2;
			end
			dpd_pkg::MODE_CK2: begin
				mode_d    = dpd_pkg::MODE_HUNT;
				res.valid = 1'b1;
				res.count = len_ext[dpd_pkg::CountW-1:0];
				if (hex.ok && !bad_q && {hi_q, hex.val} == sum_q) begin
					res.kind = dpd_pkg::KIND_GOOD;
				end else begin
					res.kind = dpd_pkg::KIND_BAD;
				end
			end
			default: begin
				if (byte_s1 == dpd_pkg::ChStart) begin
					sum_d  = '0;
					len_d  = '0;
					mode_d = dpd_pkg::MODE_BODY;
				end else begin
					mode_d    = dpd_pkg::MODE_HUNT;
					res.valid = 1'b1;
					res.kind  = dpd_pkg::KIND_STRAY;
					res.data  = byte_s1;
				end
			end
		endcase

		// Emit a payload byte, or drop the packet once the limit is reached.
		if (do_pay) begin
			res.valid = 1'b1;
			if (len_inc >= (LenW+1)'(MAX_PAYLOAD)) begin
				mode_d   = dpd_pkg::MODE_HUNT;
				res.kind = dpd_pkg::KIND_OVER;
			end else begin
				len_d     = len_inc[LenW-1:0];
				mode_d    = dpd_pkg::MODE_BODY;
				res.kind  = dpd_pkg::KIND_DATA;
				res.data  = pay_b;
				res.count = len_ext[dpd_pkg::CountW-1:0];
			end
		end
	end

endmodule

// ===== src/debug_packet_deframer_top.sv =====
// Top level of the debug packet deframer: input register, deframing engine
// and result register. Depends on dpd_pkg and dpd_engine.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   rx_byte
//   out      source     out_valid / out_stall result_kind, data_byte, count
//
// One request is taken per cycle while in_stall is low; a byte is
// registered, decoded from the input register and its result lands in the
// output register.
// Bytes that yield no result (start, end mark, escape, first checksum digit)
// still pass through the stage but never occupy the output register.
// A held result stalls the decode stage only; the input stalls only while
// a byte waits in the stage behind a held result.
// Reset clears the mode to hunting and empties both registers.
module debug_packet_deframer_top #(
	parameter int MAX_PAYLOAD = dpd_pkg::MaxPayloadDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [dpd_pkg::ByteW-1:0]   rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  result_kind,
	output logic [dpd_pkg::ByteW-1:0]   data_byte,
	output logic [dpd_pkg::CountW-1:0]  count
);

	logic                       valid_s1;
	logic [dpd_pkg::ByteW-1:0]  byte_s1;
	logic                       out_valid_q;
	dpd_pkg::kind_t             kind_q;
	logic [dpd_pkg::ByteW-1:0]  data_q;
	logic [dpd_pkg::CountW-1:0] count_q;

	logic                       out_free;
	logic                       advance;
	dpd_pkg::result_t           res;

	// The output register can take a new result when empty or draining.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register: hold the byte while the decode stage is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	dpd_engine #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// Result register: load a result only when the decoded byte made one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.valid) begin
			kind_q  <= res.kind;
			data_q  <= res.data;
			count_q <= res.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign data_byte   = data_q;
	assign count       = count_q;

endmodule

// ===== dv/debug_packet_deframer_top_tb.sv =====
// Self-checking testbench for debug_packet_deframer_top: a directed table,
// then random packets, noise and broken frames under four idling phases.
// Depends on dpd_pkg and the deframer RTL; predicts every result not typed in the table.
module debug_packet_deframer_top_tb;
	import dpd_pkg::*;

	localparam int MaxPay = MaxPayloadDef;

	// One predicted result, as the output channel carries it.
	typedef struct packed {
		kind_t             kind;
		logic [ByteW-1:0]  data;
		logic [CountW-1:0] cnt;
	} frame_res_t;

	// Directed table row: the byte to send and, where typed, the result it
	// must give (has == 0 means no result at all).
	typedef struct packed {
		logic [ByteW-1:0]  b;
		bit                typed;
		bit                has;
		kind_t             kind;
		logic [ByteW-1:0]  data;
		logic [CountW-1:0] cnt;
	} dir_row_t;

	localparam int DirRows = 24;
	localparam dir_row_t DirTab [DirRows] = '{
		// stray bytes at both extremes while hunting
		'{8'h00,    1'b1, 1'b1, KIND_STRAY,   8'h00, 10'd0},
		'{8'hFF,    1'b1, 1'b1, KIND_STRAY,   8'hFF, 10'd0},
		// start, then an escaped close brace and a top-value data byte
		'{ChStart,  1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{ChEscape, 1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h5D,    1'b1, 1'b1, KIND_DATA,    8'h7D, 10'd0},
		'{8'hFF,    1'b1, 1'b1, KIND_DATA,    8'hFF, 10'd1},
		// unescaped start inside the body restarts the packet
		'{ChStart,  1'b1, 1'b1, KIND_RESTART, 8'h00, 10'd0},
		// escaped start is plain data; upper and lower case digits mismatch
		'{ChEscape, 1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h04,    1'b1, 1'b1, KIND_DATA,    8'h24, 10'd0},
		'{ChEnd,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h46,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h66,    1'b0, 1'b0, KIND_DATA,    8'h00, 10'd0},
		// empty packet with checksum 00 is good
		'{ChStart,  1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{ChEnd,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h30,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h30,    1'b1, 1'b1, KIND_GOOD,    8'h00, 10'd0},
		// non-hex first digit spoils an otherwise matching checksum
		'{ChStart,  1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{ChEnd,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h67,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h30,    1'b1, 1'b1, KIND_BAD,     8'h00, 10'd0},
		// non-hex second digit likewise
		'{ChStart,  1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{ChEnd,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h30,    1'b1, 1'b0, KIND_DATA,    8'h00, 10'd0},
		'{8'h47,    1'b1, 1'b1, KIND_BAD,     8'h00, 10'd0}
	};

	// Idling per phase: no idling, sender idle, receiver stalling, both.
	localparam int PhaseCount = 4;
	localparam int SendIdle  [PhaseCount] = '{0, 83, 0, 13};
	localparam int RecvStall [PhaseCount] = '{0, 0, 83, 13};
	localparam int ItemsPerPhase = 30;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ByteW-1:0]  rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        result_kind;
	logic [ByteW-1:0]  data_byte;
	logic [CountW-1:0] count;

	// Predictor state: mirrors the receive side after reset.
	mode_t            fr_mode = MODE_HUNT;
	logic [ByteW-1:0] fr_sum = '0;
	int               fr_len = 0;
	logic [3:0]       fr_hi = '0;
	bit               fr_hi_bad = 1'b0;

	frame_res_t due_results [$];
	int         n_err = 0;
	int         n_items = 0;
	int         kind_seen [6] = '{default: 0};
	int         idle_pct = 0;
	int         stall_pct = 0;

	debug_packet_deframer_top #(
		.MAX_PAYLOAD(MaxPay)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_kind(result_kind),
		.data_byte  (data_byte),
		.count      (count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Decode one checksum digit; a non-hex byte reads as zero.
	function automatic bit hex_nib(input logic [ByteW-1:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h41 + 8'd10);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h61 + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Emit one body byte, or overflow once the length would reach the limit.
	function automatic bit take_payload(input logic [ByteW-1:0] b, output frame_res_t r);
		r = '{kind: KIND_DATA, data: 8'h00, cnt: 10'd0};
		if (fr_len + 1 >= MaxPay) begin
			fr_mode = MODE_HUNT;
			r.kind = KIND_OVER;
			return 1'b1;
		end
		r.data = b;
		r.cnt = fr_len[CountW-1:0];
		fr_len++;
		fr_mode = MODE_BODY;
		return 1'b1;
	endfunction

	// Advance the predicted receive state by one byte; return 1 with the
	// expected result in r when the byte yields one.
	function automatic bit deframe_step(input logic [ByteW-1:0] c, output frame_res_t r);
		logic [3:0] lo;
		bit         lo_ok;
		r = '{kind: KIND_DATA, data: 8'h00, cnt: 10'd0};
		case (fr_mode)
			MODE_BODY: begin
				if (c == ChEnd) begin
					fr_mode = MODE_CK1;
					return 1'b0;
				end
				if (c == ChStart) begin
					fr_sum = '0;
					fr_len = 0;
					r.kind = KIND_RESTART;
					return 1'b1;
				end
				fr_sum = fr_sum + c;
				if (c == ChEscape) begin
					fr_mode = MODE_ESC;
					return 1'b0;
				end
				return take_payload(c, r);
			end
			MODE_ESC: begin
				fr_sum = fr_sum + c;
				return take_payload(c ^ EscXor, r);
			end
			MODE_CK1: begin
				fr_hi_bad = !hex_nib(c, fr_hi);
				fr_mode = MODE_CK2;
				return 1'b0;
			end
			MODE_CK2: begin
				lo_ok = hex_nib(c, lo);
				fr_mode = MODE_HUNT;
				r.cnt = fr_len[CountW-1:0];
				r.kind = (lo_ok && !fr_hi_bad && {fr_hi, lo} == fr_sum) ? KIND_GOOD : KIND_BAD;
				return 1'b1;
			end
			default: begin
				if (c == ChStart) begin
					fr_sum = '0;
					fr_len = 0;
					fr_mode = MODE_BODY;
					return 1'b0;
				end
				r.kind = KIND_STRAY;
				r.data = c;
				return 1'b1;
			end
		endcase
	endfunction

	// Offer one request, idling first at random; return once it is taken.
	// Valid stays high on return so back-to-back requests need no gap.
	task automatic offer_byte(input logic [ByteW-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			rx_byte <= ByteW'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_items++;
	endtask

	// Send a byte and queue whatever result the predictor expects from it.
	task automatic send_rx(input logic [ByteW-1:0] b);
		frame_res_t r;
		offer_byte(b);
		if (deframe_step(b, r)) due_results.push_back(r);
	endtask

	function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + v;
		// pick the letter case at random
		return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function automatic logic [ByteW-1:0] non_hex();
		logic [ByteW-1:0] b;
		logic [3:0]       dummy;
		do b = ByteW'($urandom); while (hex_nib(b, dummy));
		return b;
	endfunction

	// A random byte that is none of the framing characters.
	function automatic logic [ByteW-1:0] plain_byte();
		logic [ByteW-1:0] b;
		b = ByteW'($urandom);
		if (b == ChStart || b == ChEnd || b == ChEscape) b ^= 8'h01;
		return b;
	endfunction

	// Noise between packets: a few stray bytes, never a start byte.
	task automatic send_noise();
		int               n;
		logic [ByteW-1:0] b;
		n = $urandom_range(3, 1);
		for (int i = 0; i < n; i++) begin
			b = ByteW'($urandom);
			if (b == ChStart) b ^= 8'h01;
			send_rx(b);
		end
	endtask

	// One framed packet with random body. cut = 1 drops the trailer after
	// the body, cut = 2 after the first digit, so the next start byte lands
	// as a restart or as the second digit.
	task automatic send_packet(input int max_body, input int cut);
		int               n;
		int               sel;
		logic [ByteW-1:0] s;
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] ck;
		n = $urandom_range(max_body);
		s = '0;
		send_rx(ChStart);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 12) begin
				// escape pair; the escaped byte may be any value
				b = ByteW'($urandom);
				send_rx(ChEscape);
				send_rx(b);
				s = s + ChEscape + b;
			end else if (sel < 14) begin
				send_rx(ChStart);
				s = '0;
			end else begin
				b = plain_byte();
				send_rx(b);
				s = s + b;
			end
		end
		if (cut == 1) return;
		send_rx(ChEnd);
		ck = s;
		sel = $urandom_range(99);
		if (sel >= 70 && sel < 82) ck ^= 8'(1 << $urandom_range(7));
		send_rx(sel >= 82 && sel < 91 ? non_hex() : hex_char(ck[7:4]));
		if (cut == 2) return;
		send_rx(sel >= 91 ? non_hex() : hex_char(ck[3:0]));
	endtask

	// Long packet that runs into the payload limit; the trailer that
	// follows arrives while hunting and comes back as stray bytes.
	task automatic send_overflow();
		// escape, '0', end mark, '0', '0' returns to hunting from any mode
		send_rx(ChEscape);
		send_rx(8'h30);
		send_rx(ChEnd);
		send_rx(8'h30);
		send_rx(8'h30);
		send_rx(ChStart);
		for (int i = 0; i < MaxPay + 4; i++) begin
			if (i % 97 == 5) begin
				send_rx(ChEscape);
				send_rx(ByteW'($urandom));
			end else begin
				send_rx(plain_byte());
			end
		end
		send_rx(ChEnd);
		send_rx(8'h30);
		send_rx(8'h30);
	endtask

	// Receiver: stall at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Scoreboard: compare each taken result against the oldest expectation.
	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_kind < 3'd6) kind_seen[result_kind]++;
			if (due_results.size() == 0) begin
				n_err++;
				$display("%0t: unexpected result kind %0d data %02h count %0d",
					$time, result_kind, data_byte, count);
			end else begin
				want = due_results.pop_front();
				if (result_kind !== want.kind || data_byte !== want.data ||
						count !== want.cnt) begin
					n_err++;
					$display("%0t: expected kind %0d data %02h count %0d, got kind %0d data %02h count %0d",
						$time, want.kind, want.data, want.cnt,
						result_kind, data_byte, count);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		frame_res_t r;
		int         target;
		int         sel;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PhaseCount; ph++) begin
			idle_pct = SendIdle[ph];
			stall_pct = RecvStall[ph];
			if (ph == 0) begin
				// directed table: take the typed result where given,
				// else the predictor's; advance the predictor either way
				for (int i = 0; i < DirRows; i++) begin
					offer_byte(DirTab[i].b);
					if (!DirTab[i].typed) begin
						if (deframe_step(DirTab[i].b, r)) due_results.push_back(r);
					end else begin
						void'(deframe_step(DirTab[i].b, r));
						if (DirTab[i].has)
							due_results.push_back('{kind: DirTab[i].kind,
								data: DirTab[i].data, cnt: DirTab[i].cnt});
					end
				end
			end
			target = n_items + ItemsPerPhase;
			while (n_items < target) begin
				sel = $urandom_range(99);
				if (sel < 12)
					send_noise();
				else
					send_packet(sel < 20 ? 48 : 10, sel >= 97 ? 2 : (sel >= 94 ? 1 : 0));
			end
			if (ph == PhaseCount - 1) send_overflow();
		end
		in_valid <= 1'b0;
		// drain, then give any surplus result time to show itself
		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d requests over %0d idling phases, the last ending in an overflow",
			n_items, PhaseCount);
		$display("results: %0d payload, %0d good, %0d bad, %0d overflow, %0d stray, %0d restart",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
		if (n_err == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
src/dpd_pkg.sv
src/dpd_engine.sv
src/debug_packet_deframer_top.sv
dv/debug_packet_deframer_top_tb.sv
